/* sv/hedf_pkg.sv */
// Package for the HTML entity decode filter.
// Character codes, decode helper functions and inter-module control types.
// No dependencies.
package hedf_pkg;

    localparam int ENTITY_SIZE_DEF = 10;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] CH_L_A = 8'h61;
    localparam logic [7:0] CH_L_G = 8'h67;
    localparam logic [7:0] CH_L_L = 8'h6C;
    localparam logic [7:0] CH_L_M = 8'h6D;
    localparam logic [7:0] CH_L_O = 8'h6F;
    localparam logic [7:0] CH_L_P = 8'h70;
    localparam logic [7:0] CH_L_Q = 8'h71;
    localparam logic [7:0] CH_L_S = 8'h73;
    localparam logic [7:0] CH_L_T = 8'h74;
    localparam logic [7:0] CH_L_U = 8'h75;

    localparam logic [4:0] DIGIT_NONE = 5'd16;
    localparam logic [4:0] DIGIT_DEC_LIMIT = 5'd10;

    typedef struct packed {
        logic start;
        logic active;
        logic hex;
    } np_ctrl_t;

    typedef struct packed {
        logic consume;
        logic done;
    } np_stat_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_html_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_parse_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

/* sv/html_entity_decode_filter.sv */
// HTML entity decode filter, top level: name buffer and decode sequencer.
// Depends on hedf_pkg, hedf_numparse and hedf_outreg.
//
// Usage:
//  s_ channel takes one word per character: s_tdata is the byte, s_tuser
//  selects a plain character (0) or an entity state clear (1, no output).
//  m_ channel gives decoded bytes; m_tlast marks the final byte produced
//  by one input word. Words that produce nothing give no m_ word.
//  Plain bytes, bytes stored into a name, '&' and known names (lt, gt, quot,
//  amp, apos) are taken one per cycle while the output register can accept.
//  A numeric name is first run through the shared multiply-accumulate
//  parser, then emits its byte unless the value is zero.
//  An unknown name or a full-buffer flush is emitted one byte per cycle
//  while the output register can accept, up to ENTITY_SIZE-1 bytes;
//  s_tready stays low meanwhile. A plain byte or known name goes straight
//  into the output register; an unknown name or flush first goes to ST_SEQ.
//  Reset (aresetn low, synchronous) leaves the block outside any entity
//  with an empty output register.
//  When the receiver stalls, the output word holds and s_tready drops.
module html_entity_decode_filter #(
    parameter int ENTITY_SIZE = hedf_pkg::ENTITY_SIZE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic [0:0] s_tuser,   // [0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last
);

    localparam int NAME_CAP = ENTITY_SIZE - 1;
    localparam int IDX_W    = $clog2(NAME_CAP);
    localparam int LEN_W    = $clog2(ENTITY_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NUM,
        ST_NUM_OUT,
        ST_SEQ
    } state_t;

    state_t             state_reg, state_next;
    logic               inside_reg, inside_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [IDX_W-1:0]   nlen_reg, nlen_next;
    logic               raw_reg, raw_next;
    logic [7:0]         value_reg, value_next;
    logic [7:0]         store_reg [NAME_CAP];

    logic               accept;
    logic               store_we;
    logic [IDX_W-1:0]   rd_idx;
    logic [7:0]         rd_byte;
    logic               push;
    logic [7:0]         push_data;
    logic               push_last;
    logic               can_push;
    logic               is_term;
    logic               is_num;
    logic               is_hex;
    logic               known_hit;
    logic [7:0]         known_val;
    logic [7:0]         l0, l1, l2, l3;
    logic [LEN_W:0]     len_inc;
    logic               seq_name_byte;

    hedf_pkg::np_ctrl_t np_ctrl;
    hedf_pkg::np_stat_t np_stat;
    logic [7:0]         np_value;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && can_push;
    assign is_term  = (s_tdata == hedf_pkg::CH_SEMI) || hedf_pkg::is_html_space(s_tdata);
    assign is_num   = (len_reg >= LEN_W'(1)) && (store_reg[0] == hedf_pkg::CH_HASH);
    assign is_hex   = (len_reg >= LEN_W'(2)) && (store_reg[1] == hedf_pkg::CH_X);
    assign len_inc  = {1'b0, len_reg} + (LEN_W+1)'(1);

    assign l0 = hedf_pkg::lower_byte(store_reg[0]);
    assign l1 = hedf_pkg::lower_byte(store_reg[1]);
    assign l2 = hedf_pkg::lower_byte(store_reg[2]);
    assign l3 = hedf_pkg::lower_byte(store_reg[3]);

    always_comb begin
        known_hit = 1'b1;
        known_val = hedf_pkg::CH_LT;
        if (len_reg == LEN_W'(2) && l0 == hedf_pkg::CH_L_L && l1 == hedf_pkg::CH_L_T) begin
            known_val = hedf_pkg::CH_LT;
        end else if (len_reg == LEN_W'(2) && l0 == hedf_pkg::CH_L_G
                     && l1 == hedf_pkg::CH_L_T) begin
            known_val = hedf_pkg::CH_GT;
        end else if (len_reg == LEN_W'(4) && l0 == hedf_pkg::CH_L_Q && l1 == hedf_pkg::CH_L_U
                     && l2 == hedf_pkg::CH_L_O && l3 == hedf_pkg::CH_L_T) begin
            known_val = hedf_pkg::CH_QUOT;
        end else if (len_reg == LEN_W'(3) && l0 == hedf_pkg::CH_L_A && l1 == hedf_pkg::CH_L_M
                     && l2 == hedf_pkg::CH_L_P) begin
            known_val = hedf_pkg::CH_AMP;
        end else if (len_reg == LEN_W'(4) && l0 == hedf_pkg::CH_L_A && l1 == hedf_pkg::CH_L_P
                     && l2 == hedf_pkg::CH_L_O && l3 == hedf_pkg::CH_L_S) begin
            known_val = hedf_pkg::CH_APOS;
        end else begin
            known_hit = 1'b0;
        end
    end

    // unknown name layout: '&', name bytes, ';'
    assign seq_name_byte = (pos_reg != '0) && ({1'b0, pos_reg} <= {1'b0, nlen_reg});

    always_comb begin
        rd_idx = pos_reg;
        if (state_reg == ST_SEQ && !raw_reg) begin
            rd_idx = pos_reg - IDX_W'(1);
        end
    end

    assign rd_byte = store_reg[rd_idx];

    always_comb begin
        state_next     = state_reg;
        inside_next    = inside_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        nlen_next      = nlen_reg;
        raw_next       = raw_reg;
        value_next     = value_reg;
        store_we       = 1'b0;
        push           = 1'b0;
        push_data      = s_tdata;
        push_last      = 1'b1;
        np_ctrl.start  = 1'b0;
        np_ctrl.active = (state_reg == ST_NUM);
        np_ctrl.hex    = is_hex;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        inside_next = 1'b0;
                        len_next    = '0;
                    end else if (!inside_reg) begin
                        if (s_tdata == hedf_pkg::CH_AMP) begin
                            inside_next = 1'b1;
                            len_next    = '0;
                        end else begin
                            push = 1'b1;
                        end
                    end else if (is_term) begin
                        inside_next = 1'b0;
                        len_next    = '0;
                        nlen_next   = len_reg[IDX_W-1:0];
                        if (is_num) begin
                            np_ctrl.start = 1'b1;
                            pos_next      = is_hex ? IDX_W'(2) : IDX_W'(1);
                            state_next    = ST_NUM;
                        end else if (known_hit) begin
                            push      = 1'b1;
                            push_data = known_val;
                        end else begin
                            raw_next   = 1'b0;
                            pos_next   = '0;
                            end_next   = (len_inc < (LEN_W+1)'(NAME_CAP))
                                         ? len_inc[IDX_W-1:0] : IDX_W'(NAME_CAP - 1);
                            state_next = ST_SEQ;
                        end
                    end else begin
                        store_we = 1'b1;
                        len_next = len_inc[LEN_W-1:0];
                        if (len_inc == (LEN_W+1)'(NAME_CAP)) begin
                            inside_next = 1'b0;
                            len_next    = '0;
                            raw_next    = 1'b1;
                            pos_next    = '0;
                            end_next    = IDX_W'(NAME_CAP - 1);
                            state_next  = ST_SEQ;
                        end
                    end
                end
            end
            ST_NUM: begin
                if (np_stat.consume) begin
                    pos_next = pos_reg + IDX_W'(1);
                end
                if (np_stat.done) begin
                    value_next = np_value;
                    state_next = (np_value != 8'd0) ? ST_NUM_OUT : ST_IDLE;
                end
            end
            ST_NUM_OUT: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_data  = value_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SEQ: begin
                if (raw_reg || seq_name_byte) begin
                    push_data = rd_byte;
                end else if (pos_reg == '0) begin
                    push_data = hedf_pkg::CH_AMP;
                end else begin
                    push_data = hedf_pkg::CH_SEMI;
                end
                push_last = (pos_reg == end_reg);
                if (can_push) begin
                    push     = 1'b1;
                    pos_next = pos_reg + IDX_W'(1);
                    if (pos_reg == end_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            inside_reg <= 1'b0;
            len_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
            len_reg    <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        end_reg   <= end_next;
        nlen_reg  <= nlen_next;
        raw_reg   <= raw_next;
        value_reg <= value_next;
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[len_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    hedf_numparse u_numparse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (np_ctrl),
        .at_end  (pos_reg == nlen_reg),
        .byte_in (rd_byte),
        .stat    (np_stat),
        .value   (np_value)
    );

    hedf_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .push_last (push_last),
        .can_push  (can_push),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* sv/hedf_numparse.sv */
// Iterative numeric entity parser: at most one name byte per cycle (some phase
// changes take none) through a shared multiply-accumulate unit (x10 or x16, modulo 256).
// Depends on hedf_pkg.
module hedf_numparse (
    input  logic              aclk,
    input  logic              aresetn,
    input  hedf_pkg::np_ctrl_t ctrl,
    input  logic              at_end,
    input  logic [7:0]        byte_in,
    output hedf_pkg::np_stat_t stat,
    output logic [7:0]        value
);

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_PFX0,
        PH_PFX1,
        PH_PFX2,
        PH_DIG
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] acc_reg, acc_next;
    logic       neg_reg, neg_next;
    logic       hex_reg, hex_next;

    logic [4:0] digit;
    logic       digit_ok;
    logic [7:0] acc_mul;

    assign digit    = hedf_pkg::digit_value(byte_in);
    assign digit_ok = hex_reg ? (digit != hedf_pkg::DIGIT_NONE)
                              : (digit < hedf_pkg::DIGIT_DEC_LIMIT);
    assign acc_mul  = hex_reg ? {acc_reg[3:0], 4'b0000}
                              : ({acc_reg[4:0], 3'b000} + {acc_reg[6:0], 1'b0});
    assign value    = neg_reg ? 8'(8'd0 - acc_reg) : acc_reg;

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        hex_next     = hex_reg;
        stat.consume = 1'b0;
        stat.done    = 1'b0;
        if (ctrl.start) begin
            phase_next = PH_WS;
            acc_next   = 8'd0;
            neg_next   = 1'b0;
            hex_next   = ctrl.hex;
        end else if (ctrl.active) begin
            if (at_end) begin
                stat.done = 1'b1;
            end else begin
                case (phase_reg)
                    PH_WS: begin
                        if (hedf_pkg::is_parse_space(byte_in)) begin
                            stat.consume = 1'b1;
                        end else begin
                            phase_next = PH_SIGN;
                        end
                    end
                    PH_SIGN: begin
                        if (byte_in == hedf_pkg::CH_PLUS || byte_in == hedf_pkg::CH_MINUS) begin
                            stat.consume = 1'b1;
                            neg_next     = (byte_in == hedf_pkg::CH_MINUS);
                        end
                        phase_next = hex_reg ? PH_PFX0 : PH_DIG;
                    end
                    PH_PFX0: begin
                        if (byte_in == hedf_pkg::CH_ZERO) begin
                            stat.consume = 1'b1;
                            phase_next   = PH_PFX1;
                        end else begin
                            phase_next = PH_DIG;
                        end
                    end
                    PH_PFX1: begin
                        if (hedf_pkg::lower_byte(byte_in) == hedf_pkg::CH_X) begin
                            stat.consume = 1'b1;
                            phase_next   = PH_PFX2;
                        end else begin
                            phase_next = PH_DIG;
                        end
                    end
                    PH_PFX2: begin
                        // "0x" only counts as a prefix when a digit follows
                        if (digit_ok) begin
                            phase_next = PH_DIG;
                        end else begin
                            stat.done = 1'b1;
                        end
                    end
                    PH_DIG: begin
                        if (digit_ok) begin
                            stat.consume = 1'b1;
                            acc_next     = acc_mul + {4'b0000, digit[3:0]};
                        end else begin
                            stat.done = 1'b1;
                        end
                    end
                    default: begin
                        stat.done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WS;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        hex_reg <= hex_next;
    end

endmodule

/* sv/hedf_outreg.sv */
// Output register stage for the decoded byte stream.
// Holds one word until the receiver takes it. No package dependency.
module hedf_outreg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       push_last,
    output logic       can_push,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign can_push   = !valid_reg || m_tready;
    assign valid_next = push || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
            last_reg <= push_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
